>>> hdl/nsfc_pkg.sv
package nsfc_pkg;

  // Framing characters.
  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  // Default limit on bytes per sentence, the dollar included.
  localparam int unsigned MAX_LEN_DEF = 128;

  // Sentence headers, the first character in the high byte.
  localparam logic [39:0] HDR_GPGGA = 40'h4750474741;
  localparam logic [39:0] HDR_GPRMC = 40'h4750524D43;
  localparam logic [39:0] HDR_PGRME = 40'h5047524D45;
  localparam logic [39:0] HDR_GPGST = 40'h4750475354;

  // Number of header characters that identify a sentence.
  localparam logic [7:0] HDR_CHARS = 8'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_NO_SUM   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_GPGGA = 3'd1,
    KIND_GPRMC = 3'd2,
    KIND_PGRME = 3'd3,
    KIND_GPGST = 3'd4
  } kind_t;

  // One result word as it leaves the block.
  typedef struct packed {
    status_t     status;
    kind_t       sentence_kind;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic [7:0]  body_length;
  } result_t;

  // Result word together with its valid flag, from the core to the output stage.
  typedef struct packed {
    logic    valid;
    result_t data;
  } result_msg_t;

  // Hex digit decode: bit 4 flags a legal digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // Sentence kind from the first five body characters.
  function automatic kind_t kind_of(input logic [39:0] hdr, input logic [7:0] count);
    kind_t k;
    k = KIND_OTHER;
    if (count >= HDR_CHARS) begin
      if (hdr == HDR_GPGGA) begin
        k = KIND_GPGGA;
      end else if (hdr == HDR_GPRMC) begin
        k = KIND_GPRMC;
      end else if (hdr == HDR_PGRME) begin
        k = KIND_PGRME;
      end else if (hdr == HDR_GPGST) begin
        k = KIND_GPGST;
      end
    end
    return k;
  endfunction

endpackage

>>> hdl/nsfc_core.sv
module nsfc_core import nsfc_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output result_msg_t res
);

  logic        in_sentence_r, in_sentence_nxt;
  logic [7:0]  pending_char_r, pending_char_nxt;
  logic        pending_valid_r, pending_valid_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic        star_seen_r, star_seen_nxt;
  logic [1:0]  after_star_r, after_star_nxt;
  logic [7:0]  hex_value_r, hex_value_nxt;
  logic        hex_ok_r, hex_ok_nxt;
  logic [7:0]  char_count_r, char_count_nxt;
  logic [39:0] header_r, header_nxt;

  logic        sum_ok;
  logic        overflow;
  logic [8:0]  bytes_so_far;
  logic [4:0]  digit;

  localparam logic [8:0] LIMIT = 9'(MAX_LEN);

  // Bytes since the dollar, the dollar and this byte included.
  assign bytes_so_far = 9'd2 + {1'b0, char_count_r} + {8'd0, pending_valid_r};
  assign overflow     = bytes_so_far >= LIMIT;
  assign sum_ok       = star_seen_r && (after_star_r == 2'd2) && hex_ok_r;
  assign digit        = hex_digit(pending_char_r);

  // Next sentence state and the result of this word.
  always_comb begin
    in_sentence_nxt   = in_sentence_r;
    pending_char_nxt  = pending_char_r;
    pending_valid_nxt = pending_valid_r;
    running_xor_nxt   = running_xor_r;
    star_seen_nxt     = star_seen_r;
    after_star_nxt    = after_star_r;
    hex_value_nxt     = hex_value_r;
    hex_ok_nxt        = hex_ok_r;
    char_count_nxt    = char_count_r;
    header_nxt        = header_r;
    res               = '0;

    if (step) begin
      if (!in_sentence_r) begin
        if (rx_byte == CH_START) begin
          in_sentence_nxt = 1'b1;
        end
      end else if (rx_byte == CH_END || overflow) begin
        res.valid = 1'b1;
        if (rx_byte == CH_END) begin
          res.data.status        = sum_ok ? ((running_xor_r == hex_value_r) ? ST_OK
                                                                            : ST_MISMATCH)
                                          : ST_NO_SUM;
          res.data.sentence_kind = kind_of(header_r, char_count_r);
          res.data.computed_sum  = running_xor_r;
          res.data.received_sum  = sum_ok ? hex_value_r : 8'd0;
          res.data.body_length   = char_count_r;
        end else begin
          res.data.status = ST_OVERFLOW;
        end
        in_sentence_nxt = 1'b0;
      end else begin
        // Commit the held-back character, then hold back this one.
        if (pending_valid_r) begin
          if (char_count_r < HDR_CHARS) begin
            header_nxt = {header_r[31:0], pending_char_r};
          end
          char_count_nxt = char_count_r + 8'd1;
          if (!star_seen_r) begin
            if (pending_char_r == CH_STAR) begin
              star_seen_nxt = 1'b1;
            end else begin
              running_xor_nxt = running_xor_r ^ pending_char_r;
            end
          end else begin
            if (after_star_r < 2'd2) begin
              if (!digit[4]) begin
                hex_ok_nxt = 1'b0;
              end else begin
                hex_value_nxt = {hex_value_r[3:0], digit[3:0]};
              end
            end
            if (after_star_r != 2'd3) begin
              after_star_nxt = after_star_r + 2'd1;
            end
          end
        end
        pending_char_nxt  = rx_byte;
        pending_valid_nxt = 1'b1;
      end

      // A dollar while hunting or the end of a sentence starts from a clean slate.
      if ((!in_sentence_r && rx_byte == CH_START) || res.valid) begin
        pending_char_nxt  = 8'd0;
        pending_valid_nxt = 1'b0;
        running_xor_nxt   = 8'd0;
        star_seen_nxt     = 1'b0;
        after_star_nxt    = 2'd0;
        hex_value_nxt     = 8'd0;
        hex_ok_nxt        = 1'b1;
        char_count_nxt    = 8'd0;
        header_nxt        = 40'd0;
      end
    end
  end

  // Sentence state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r   <= 1'b0;
      pending_char_r  <= 8'd0;
      pending_valid_r <= 1'b0;
      running_xor_r   <= 8'd0;
      star_seen_r     <= 1'b0;
      after_star_r    <= 2'd0;
      hex_value_r     <= 8'd0;
      hex_ok_r        <= 1'b1;
      char_count_r    <= 8'd0;
      header_r        <= 40'd0;
    end else begin
      in_sentence_r   <= in_sentence_nxt;
      pending_char_r  <= pending_char_nxt;
      pending_valid_r <= pending_valid_nxt;
      running_xor_r   <= running_xor_nxt;
      star_seen_r     <= star_seen_nxt;
      after_star_r    <= after_star_nxt;
      hex_value_r     <= hex_value_nxt;
      hex_ok_r        <= hex_ok_nxt;
      char_count_r    <= char_count_nxt;
      header_r        <= header_nxt;
    end
  end

endmodule

>>> hdl/nsfc_out_reg.sv
module nsfc_out_reg import nsfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  result_msg_t res,
  output logic        hold,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  // The stage blocks new work only while a word sits here and is stalled.
  assign hold = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
      data_nxt  = res.data;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> hdl/nmea_sentence_framer_checker.sv
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// input    | in_valid, in_stall, in_rx_byte               | in
// result   | out_valid, out_stall, out_status,            | out
//          | out_sentence_kind, out_computed_sum,         |
//          | out_received_sum, out_body_length            |
//
// One word is taken per cycle while in_stall is low and sits in the input register
// until it steps on, where the sentence state update and the result register load
// happen together, so the result of a line feed or overflow byte is then registered.
// Reset is synchronous and active low; the block then hunts for a dollar.
// A stalled result holds the sentence state update, and the input register then
// stalls the input side once it is full.
module nmea_sentence_framer_checker import nsfc_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [2:0] out_sentence_kind,
  output logic [7:0] out_computed_sum,
  output logic [7:0] out_received_sum,
  output logic [7:0] out_body_length
);

  logic        in_full_r, in_full_nxt;
  logic [7:0]  in_byte_r;
  logic        hold;
  logic        step;
  logic        take;
  result_msg_t res;
  result_t     out_data;

  // Input register: the held word moves on unless the result stage is blocked.
  assign step     = in_full_r && !hold;
  assign in_stall = in_full_r && hold;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_full_nxt = in_full_r;
    if (take) begin
      in_full_nxt = 1'b1;
    end else if (step) begin
      in_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  nsfc_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  nsfc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status        = out_data.status;
  assign out_sentence_kind = out_data.sentence_kind;
  assign out_computed_sum  = out_data.computed_sum;
  assign out_received_sum  = out_data.received_sum;
  assign out_body_length   = out_data.body_length;

endmodule
